// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the active-low reset is asserted.
`define TPL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must never hold.
`define TPL_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) not (prop)) else $error(msg);

`endif

// ----- design/tpl_pkg.sv -----
// Widths and helpers for the tetrahedron local-coordinate pipeline.
package tpl_pkg;

  localparam int COORD_BITS = 21;
  localparam int FRAC_BITS  = 28;
  localparam int FIELD_W    = 21;
  localparam int REG_W      = 63;
  localparam int NUM_NODES  = 4;
  localparam int IDX_W      = 3;
  localparam int QW         = 32;

  localparam int EW   = COORD_BITS + 1;
  localparam int PW   = 2 * EW;
  localparam int XW   = PW + 1;
  localparam int VPW  = EW + XW;
  localparam int DOTW = VPW + 2;
  localparam int TOPW = DOTW + FRAC_BITS + 2;
  localparam int D2W  = DOTW + 1;

  localparam int DIV_LAT = QW + 2;
  localparam int LAT     = 4 + DIV_LAT;
  localparam int SETTLE  = 7;
  localparam int SET_W   = 3;

  function automatic logic signed [COORD_BITS-1:0] node_fld(input logic [REG_W-1:0] r,
                                                            input int k);
    return r[k*FIELD_W +: COORD_BITS];
  endfunction

endpackage

// ----- design/tpl_div_lane.sv -----
// Pipelined restoring divider, one quotient bit per stage, rounded and saturated.
module tpl_div_lane import tpl_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [TOPW-1:0]       top_i,
  input  logic [D2W-1:0]        d2_i,
  input  logic                  neg_i,
  output logic signed [QW-1:0]  res_o
);

  localparam int CMPW = D2W + QW;

  logic [D2W-1:0]  rem_r [QW+1];
  logic [QW-1:0]   lo_r  [QW+1];
  logic [QW-1:0]   q_r   [QW+1];
  logic [D2W-1:0]  d2_r  [QW+1];
  logic            neg_r [QW+1];
  logic            ovf_r [QW+1];
  logic [D2W-1:0]  rem_nxt [QW];
  logic [QW-1:0]   q_nxt   [QW];
  logic signed [QW-1:0] res_r;
  logic signed [QW-1:0] res_nxt;
  logic            ovf0;
  logic [D2W:0]    trial [QW];
  logic            ge    [QW];

  assign ovf0 = CMPW'(top_i) >= {d2_i, QW'(0)};

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      trial[k]   = {rem_r[k], lo_r[k][QW-1]};
      ge[k]      = trial[k] >= {1'b0, d2_r[k]};
      rem_nxt[k] = ge[k] ? D2W'(trial[k] - {1'b0, d2_r[k]}) : D2W'(trial[k]);
      q_nxt[k]   = {q_r[k][QW-2:0], ge[k]};
    end
  end

  always_comb begin
    if (!neg_r[QW]) begin
      if (ovf_r[QW] || q_r[QW][QW-1]) res_nxt = {1'b0, {(QW-1){1'b1}}};
      else                            res_nxt = q_r[QW];
    end else begin
      if (ovf_r[QW] || (q_r[QW] > {1'b1, (QW-1)'(0)})) res_nxt = {1'b1, (QW-1)'(0)};
      else                                              res_nxt = -q_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= D2W'(top_i >> QW);
      lo_r[0]  <= top_i[QW-1:0];
      q_r[0]   <= '0;
      d2_r[0]  <= d2_i;
      neg_r[0] <= neg_i;
      ovf_r[0] <= ovf0;
      for (int k = 0; k < QW; k++) begin
        rem_r[k+1] <= rem_nxt[k];
        lo_r[k+1]  <= {lo_r[k][QW-2:0], 1'b0};
        q_r[k+1]   <= q_nxt[k];
        d2_r[k+1]  <= d2_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

// ----- design/tetra_point_to_local_coords_core.sv -----
// Top level: maps a query point to local r, s, t coordinates of a linear tetrahedron.
//
//  channel | signals                                        | direction
//  cfg     | cfg_valid cfg_ready cfg_index cfg_wdata        | in
//  in      | in_valid in_ready in_point_x/y/z               | in
//  out     | out_valid out_ready out_coord_r/s/t out_degen. | out
//
// One transaction per cycle while the output is not stalled; the divider has 32 stages.
// Element terms are recomputed in a 6-deep pipeline after each cfg write;
// in_ready stays low after a write and after reset until the settle counter reaches zero.
// A stalled output freezes the point pipeline and divider lanes; nothing is lost or repeated.
`include "assert_macros.svh"
module tetra_point_to_local_coords_core import tpl_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [IDX_W-1:0]             cfg_index,
  input  logic [REG_W-1:0]             cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [FIELD_W-1:0]    in_point_x,
  input  logic signed [FIELD_W-1:0]    in_point_y,
  input  logic signed [FIELD_W-1:0]    in_point_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [QW-1:0]         out_coord_r,
  output logic signed [QW-1:0]         out_coord_s,
  output logic signed [QW-1:0]         out_coord_t,
  output logic                         out_degenerate
);

  logic [REG_W-1:0] node_r [NUM_NODES];
  logic [SET_W-1:0] settle_r;
  logic             cfg_wr;

  logic signed [EW-1:0]   e_r  [3][3];
  logic signed [PW-1:0]   pa_r [3][3];
  logic signed [PW-1:0]   pb_r [3][3];
  logic signed [XW-1:0]   c_r  [3][3];
  logic signed [VPW-1:0]  vp_prod_r [3];
  logic signed [DOTW-1:0] vol_r;
  logic [DOTW-1:0]        vmag_r;
  logic                   vneg_r;
  logic                   vzero_r;

  logic                   adv;
  logic                   accept;
  logic [LAT-1:0]         vp_r;
  logic signed [FIELD_W-1:0] pt [3];
  logic signed [EW-1:0]   d_r  [3];
  logic signed [VPW-1:0]  np_r [3][3];
  logic signed [DOTW-1:0] n_r  [3];
  logic [TOPW-1:0]        top_r [3];
  logic [D2W-1:0]         d2_r;
  logic                   neg_r [3];
  logic [DOTW-1:0]        nmag  [3];
  logic signed [QW-1:0]   res   [3];

  logic                   out_valid_r;
  logic signed [QW-1:0]   coord_r_r, coord_s_r, coord_t_r;
  logic                   degen_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_NODES; k++) node_r[k] <= '0;
      settle_r <= SET_W'(SETTLE);
    end else if (cfg_wr) begin
      if (cfg_index < IDX_W'(NUM_NODES)) node_r[cfg_index[1:0]] <= cfg_wdata;
      settle_r <= SET_W'(SETTLE);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  // element terms: edges, cofactors, determinant
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        e_r[j][i] <= EW'(node_fld(node_r[j+1], i)) - EW'(node_fld(node_r[0], i));
        pa_r[j][i] <= e_r[(j+1)%3][(i+1)%3] * e_r[(j+2)%3][(i+2)%3];
        pb_r[j][i] <= e_r[(j+1)%3][(i+2)%3] * e_r[(j+2)%3][(i+1)%3];
        c_r[j][i]  <= XW'(pa_r[j][i]) - XW'(pb_r[j][i]);
      end
    end
    for (int i = 0; i < 3; i++) vp_prod_r[i] <= VPW'(e_r[0][i]) * VPW'(c_r[0][i]);
    vol_r   <= DOTW'(vp_prod_r[0]) + DOTW'(vp_prod_r[1]) + DOTW'(vp_prod_r[2]);
    vneg_r  <= vol_r[DOTW-1];
    vmag_r  <= vol_r[DOTW-1] ? DOTW'(-vol_r) : DOTW'(vol_r);
    vzero_r <= vol_r == '0;
  end

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && (settle_r == '0);
  assign accept   = in_valid && in_ready;

  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;

  always_comb begin
    for (int j = 0; j < 3; j++) nmag[j] = n_r[j][DOTW-1] ? DOTW'(-n_r[j]) : DOTW'(n_r[j]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++)
        d_r[i] <= EW'($signed(pt[i][COORD_BITS-1:0])) - EW'(node_fld(node_r[0], i));
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) np_r[j][i] <= VPW'(d_r[i]) * VPW'(c_r[j][i]);
        n_r[j]   <= DOTW'(np_r[j][0]) + DOTW'(np_r[j][1]) + DOTW'(np_r[j][2]);
        neg_r[j] <= n_r[j][DOTW-1] ^ vneg_r;
        top_r[j] <= (TOPW'(nmag[j]) << (FRAC_BITS + 1)) + TOPW'(vmag_r);
      end
      d2_r <= {vmag_r, 1'b0};
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    tpl_div_lane u_div (
      .clk   (clk),
      .en    (adv),
      .top_i (top_r[j]),
      .d2_i  (d2_r),
      .neg_i (neg_r[j]),
      .res_o (res[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vp_r        <= {vp_r[LAT-2:0], accept};
      out_valid_r <= vp_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      coord_r_r <= vzero_r ? '0 : res[0];
      coord_s_r <= vzero_r ? '0 : res[1];
      coord_t_r <= vzero_r ? '0 : res[2];
      degen_r   <= vzero_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_coord_r    = coord_r_r;
  assign out_coord_s    = coord_s_r;
  assign out_coord_t    = coord_t_r;
  assign out_degenerate = degen_r;

  `TPL_ASSERT(a_degen_zero, clk, rst_n, out_valid && out_degenerate |-> out_coord_r == '0 && out_coord_s == '0 && out_coord_t == '0, "degenerate result with nonzero coordinates")
  `TPL_ASSERT(a_cfg_blocks_in, clk, rst_n, cfg_valid && cfg_ready |=> !in_ready, "input accepted while element terms settle")
  `TPL_NEVER(a_stall_holds, clk, rst_n, !adv ##1 (vp_r != $past(vp_r)), "pipeline moved during stall")

endmodule

// ----- bench/tpl_checker.sv -----
// Checker for the tetrahedron local-coordinate block: predicts and compares each result.
`timescale 1ns / 1ps
module tpl_checker import tpl_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [REG_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [FIELD_W-1:0] in_point_x,
  input  logic signed [FIELD_W-1:0] in_point_y,
  input  logic signed [FIELD_W-1:0] in_point_z,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [QW-1:0]      out_coord_r,
  input  logic signed [QW-1:0]      out_coord_s,
  input  logic signed [QW-1:0]      out_coord_t,
  input  logic                      out_degenerate,
  output int                        errors,
  output int                        pending,
  output int                        results_seen,
  output int                        degen_seen
);

  typedef struct packed {
    logic [QW-1:0] r;
    logic [QW-1:0] s;
    logic [QW-1:0] t;
    logic          degen;
  } local_coords_t;

  typedef longint vec3_t [3];

  logic [REG_W-1:0] node_regs [NUM_NODES];
  local_coords_t    expected_coords [$];

  function automatic longint fld(input logic [REG_W-1:0] r, input int k);
    logic signed [COORD_BITS-1:0] v;
    v = r[k*FIELD_W +: COORD_BITS];
    return longint'(v);
  endfunction

  function automatic logic signed [127:0] dot3(input vec3_t a, input vec3_t b);
    logic signed [127:0] s, ta, tb;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      ta = a[i];
      tb = b[i];
      s = s + ta * tb;
    end
    return s;
  endfunction

  function automatic logic [QW-1:0] fixed_div(input logic signed [127:0] num,
                                              input logic signed [127:0] den);
    logic          neg;
    logic [127:0]  mn, md, top, m;
    neg = (num < 0) != (den < 0);
    mn  = (num < 0) ? -num : num;
    md  = (den < 0) ? -den : den;
    top = (mn << (FRAC_BITS + 1)) + md;
    m   = top / (md << 1);
    if (!neg) begin
      return (m > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[QW-1:0];
    end else begin
      return (m > 128'h8000_0000) ? 32'h8000_0000 : -m[QW-1:0];
    end
  endfunction

  function automatic local_coords_t predict_coords(input logic [FIELD_W-1:0] px,
                                                   input logic [FIELD_W-1:0] py,
                                                   input logic [FIELD_W-1:0] pz);
    vec3_t p0, e1, e2, e3, d, c23, c31, c12;
    logic [REG_W-1:0] pt;
    logic signed [127:0] vol;
    local_coords_t res;
    pt = {pz, py, px};
    for (int i = 0; i < 3; i++) begin
      p0[i] = fld(node_regs[0], i);
      e1[i] = fld(node_regs[1], i) - p0[i];
      e2[i] = fld(node_regs[2], i) - p0[i];
      e3[i] = fld(node_regs[3], i) - p0[i];
      d[i]  = fld(pt, i) - p0[i];
    end
    c23[0] = e2[1]*e3[2] - e2[2]*e3[1];
    c23[1] = e2[2]*e3[0] - e2[0]*e3[2];
    c23[2] = e2[0]*e3[1] - e2[1]*e3[0];
    c31[0] = e3[1]*e1[2] - e3[2]*e1[1];
    c31[1] = e3[2]*e1[0] - e3[0]*e1[2];
    c31[2] = e3[0]*e1[1] - e3[1]*e1[0];
    c12[0] = e1[1]*e2[2] - e1[2]*e2[1];
    c12[1] = e1[2]*e2[0] - e1[0]*e2[2];
    c12[2] = e1[0]*e2[1] - e1[1]*e2[0];
    vol = dot3(e1, c23);
    if (vol == 0) begin
      res = '{r: '0, s: '0, t: '0, degen: 1'b1};
    end else begin
      res.r = fixed_div(dot3(d, c23), vol);
      res.s = fixed_div(dot3(d, c31), vol);
      res.t = fixed_div(dot3(d, c12), vol);
      res.degen = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    local_coords_t exp_c, got;
    if (!rst_n) begin
      for (int k = 0; k < NUM_NODES; k++) node_regs[k] <= '0;
      expected_coords.delete();
      errors <= 0;
      pending <= 0;
      results_seen <= 0;
      degen_seen <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_coords.push_back(predict_coords(in_point_x, in_point_y, in_point_z));
      if (cfg_valid && cfg_ready && cfg_index < NUM_NODES)
        node_regs[cfg_index] <= cfg_wdata;
      if (out_valid && out_ready) begin
        got = '{r: out_coord_r, s: out_coord_s, t: out_coord_t, degen: out_degenerate};
        results_seen <= results_seen + 1;
        if (out_degenerate) degen_seen <= degen_seen + 1;
        if (expected_coords.size() == 0) begin
          $display("%0t: unexpected transaction r=%h s=%h t=%h degen=%b",
                   $time, got.r, got.s, got.t, got.degen);
          errors <= errors + 1;
        end else begin
          exp_c = expected_coords.pop_front();
          if (got !== exp_c) begin
            $display("%0t: mismatch expected r=%h s=%h t=%h degen=%b", $time,
                     exp_c.r, exp_c.s, exp_c.t, exp_c.degen);
            $display("%0t:          actual   r=%h s=%h t=%h degen=%b", $time,
                     got.r, got.s, got.t, got.degen);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_coords.size();
    end
  end

endmodule

// ----- bench/tetra_point_to_local_coords_core_tb.sv -----
// Testbench top: stimulus, idling and verdict for the tetrahedron local-coordinate block.
`timescale 1ns / 1ps
module tetra_point_to_local_coords_core_tb;
  import tpl_pkg::*;

  localparam logic [IDX_W-1:0] IDX_NODE0 = 3'd0;
  localparam logic [IDX_W-1:0] IDX_NODE1 = 3'd1;
  localparam logic [IDX_W-1:0] IDX_NODE2 = 3'd2;
  localparam logic [IDX_W-1:0] IDX_NODE3 = 3'd3;
  localparam logic [IDX_W-1:0] IDX_UNUSED = 3'd5;
  localparam int CMIN = -(1 << (COORD_BITS - 1));
  localparam int CMAX = (1 << (COORD_BITS - 1)) - 1;
  localparam int ITEMS_PER_SET = 140;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_wdata;
  logic in_valid, in_ready;
  logic signed [FIELD_W-1:0] in_point_x, in_point_y, in_point_z;
  logic out_valid, out_ready;
  logic signed [QW-1:0] out_coord_r, out_coord_s, out_coord_t;
  logic out_degenerate;
  int errors, pending, results_seen, degen_seen;
  int sent, idle_mode, stall_cycles, n_cfgs;
  int node_c [4][3];

  tetra_point_to_local_coords_core u_dut (.*);

  tpl_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_valid = 1'b0; in_point_x = '0; in_point_y = '0; in_point_z = '0;
    out_ready = 1'b0;
    idle_mode = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
  end

  always @(negedge clk) begin
    if (rst_n)
      out_ready <= ($urandom_range(99) >= (idle_mode == 0 ? 68 : idle_mode == 1 ? 37 : 0));
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d idle cycles", stall_cycles);
      $display("Verification failed");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

  task automatic send_point(input int x, input int y, input int z);
    int pct;
    pct = (idle_mode == 0) ? 37 : (idle_mode == 1) ? 68 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_point_x = x; in_point_y = y; in_point_z = z;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
    sent++;
    idle_mode = sent * 3 / (ITEMS_PER_SET * 7 + 40);
    if (idle_mode > 2) idle_mode = 2;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_valid = 1'b1; cfg_index = idx; cfg_wdata = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LAT + 8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_element();
    logic [REG_W-1:0] r;
    drain();
    for (int k = 0; k < 4; k++) begin
      r = {21'(node_c[k][2]), 21'(node_c[k][1]), 21'(node_c[k][0])};
      write_reg(k == 0 ? IDX_NODE0 : k == 1 ? IDX_NODE1 : k == 2 ? IDX_NODE2 : IDX_NODE3, r);
    end
    n_cfgs++;
  endtask

  function automatic int rnd_coord(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic run_points(input int count, input bit directed);
    int lo [3], hi [3];
    for (int a = 0; a < 3; a++) begin
      lo[a] = node_c[0][a]; hi[a] = node_c[0][a];
      for (int k = 1; k < 4; k++) begin
        if (node_c[k][a] < lo[a]) lo[a] = node_c[k][a];
        if (node_c[k][a] > hi[a]) hi[a] = node_c[k][a];
      end
    end
    if (directed) begin
      send_point(CMIN, CMIN, CMIN);
      send_point(CMAX, CMAX, CMAX);
      send_point(0, 0, 0);
      send_point(CMAX, CMIN, CMAX);
      for (int k = 0; k < 4; k++) send_point(node_c[k][0], node_c[k][1], node_c[k][2]);
    end
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 70)
        send_point(rnd_coord(lo[0], hi[0]), rnd_coord(lo[1], hi[1]), rnd_coord(lo[2], hi[2]));
      else
        send_point(rnd_coord(CMIN, CMAX), rnd_coord(CMIN, CMAX), rnd_coord(CMIN, CMAX));
    end
  endtask

  task automatic set_nodes(input int k, input int x, input int y, input int z);
    node_c[k][0] = x; node_c[k][1] = y; node_c[k][2] = z;
  endtask

  initial begin
    int m;
    sent = 0; n_cfgs = 0;
    for (int k = 0; k < 4; k++) set_nodes(k, 0, 0, 0);
    @(posedge rst_n);
    @(negedge clk);

    // reset element: all nodes at the origin, degenerate
    run_points(10, 1'b1);

    set_nodes(0, CMIN, CMIN, CMIN); set_nodes(1, CMAX, CMIN, CMIN);
    set_nodes(2, CMIN, CMAX, CMIN); set_nodes(3, CMIN, CMIN, CMAX);
    load_element();
    run_points(ITEMS_PER_SET, 1'b1);

    // unit element: far points saturate
    set_nodes(0, 0, 0, 0); set_nodes(1, 1, 0, 0);
    set_nodes(2, 0, 1, 0); set_nodes(3, 0, 0, 1);
    load_element();
    run_points(ITEMS_PER_SET, 1'b1);

    for (int rep = 0; rep < 3; rep++) begin
      m = (rep == 0) ? 2000 : 400000;
      for (int k = 0; k < 4; k++)
        set_nodes(k, rnd_coord(-m, m), rnd_coord(-m, m), rnd_coord(-m, m));
      load_element();
      run_points(ITEMS_PER_SET, 1'b0);
    end

    // mirrored element, negative volume
    set_nodes(0, 1000, -2000, 3000); set_nodes(1, -50000, 7000, 3000);
    set_nodes(2, 1000, 90000, -4000); set_nodes(3, 60000, 60000, 60000);
    load_element();
    run_points(ITEMS_PER_SET, 1'b0);

    // coplanar element: node 3 in the plane of the others
    set_nodes(0, 100, 200, -300); set_nodes(1, 5000, -700, 800);
    set_nodes(2, -3000, 9000, 1200);
    set_nodes(3, 5000 - 3000 - 100, -700 + 9000 - 200, 800 + 1200 + 300);
    load_element();
    write_reg(IDX_UNUSED, {REG_W{1'b1}});
    run_points(ITEMS_PER_SET, 1'b0);

    // all-ones registers: every node at -1, degenerate
    for (int k = 0; k < 4; k++) set_nodes(k, -1, -1, -1);
    load_element();
    run_points(30, 1'b0);

    drain();
    $display("Ran %0d points over %0d element settings across three idling regimes;",
             sent, n_cfgs + 1);
    $display("%0d results checked, %0d of them degenerate.", results_seen, degen_seen);
    if (errors == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- tetra_point_to_local_coords_core.f -----
+incdir+design
design/tpl_pkg.sv
design/tpl_div_lane.sv
design/tetra_point_to_local_coords_core.sv
bench/tpl_checker.sv
bench/tetra_point_to_local_coords_core_tb.sv
